// ===== hw/rtl/trdls_pkg.sv =====
// Shared types, constants and segment tables for the three-row decimal LED scanner.
// No dependencies; compile first.

package trdls_pkg;

  localparam int ROWS   = 3;
  localparam int STAGES = 7;
  localparam int DIGITS = 12;

  localparam logic [3:0] LAST_SCAN = 4'd11;

  // 2^26 / 1000 rounded up; exact floor for any 16-bit value
  localparam logic [32:0] THOU_RECIP = 33'd67109;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_ZERO  = 8'hC0;
  localparam logic [7:0] DP_MASK   = 8'h7F;

  typedef struct packed {
    logic [15:0] val;
    logic [6:0]  thou;
    logic [9:0]  rem;
    logic [3:0]  hund;
    logic [6:0]  rem2;
    logic [3:0]  tens;
    logic [3:0]  ones;
  } lane_t;

  typedef logic [7:0] byte_t;

  localparam byte_t SEG_TABLE [16] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
  };

  // Scan order: positions 4..1, 8..5, 12..9
  localparam byte_t SEL_LO [DIGITS] = '{
    8'hF7, 8'hFB, 8'hFD, 8'hFE, 8'h7F, 8'hBF, 8'hDF, 8'hEF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  localparam byte_t SEL_HI [DIGITS] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hF7, 8'hFB, 8'hFD, 8'hFE
  };

  function automatic byte_t seg_of(input logic [6:0] d);
    byte_t s;
    if (d > 7'd15) begin
      s = SEG_ZERO;
    end else begin
      s = SEG_TABLE[d[3:0]];
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/trdls_req_if.sv =====
// Refresh request channel: valid/ready handshake with three 16-bit values.
// Depends on nothing.

interface trdls_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] time_value;
  logic [15:0] score_value;
  logic [15:0] total_value;

  modport source (output valid, output time_value, output score_value,
                  output total_value, input ready);
  modport sink   (input valid, input time_value, input score_value,
                  input total_value, output ready);
endinterface

// ===== hw/rtl/trdls_digit_if.sv =====
// Digit-drive result channel: valid/ready handshake with select, segment and last.
// Depends on nothing.

interface trdls_digit_if;
  logic       valid;
  logic       ready;
  logic [7:0] select_low_byte;
  logic [7:0] select_high_byte;
  logic [7:0] segment_byte;
  logic       last_digit;

  modport source (output valid, output select_low_byte, output select_high_byte,
                  output segment_byte, output last_digit, input ready);
  modport sink   (input valid, input select_low_byte, input select_high_byte,
                  input segment_byte, input last_digit, output ready);
endinterface

// ===== hw/rtl/three_row_decimal_led_scanner_core.sv =====
// Top level: seven-stage decimal split pipeline feeding a twelve-digit scan frame.
// Depends on trdls_pkg, trdls_req_if and trdls_digit_if.
//
//   channel  dir  payload                                             beats/refresh
//   req      in   time_value, score_value, total_value                1
//   digit    out  select_low_byte, select_high_byte, segment_byte,   12
//                 last_digit
//
// An accepted request moves through the pipeline stages into the scan frame; its
// first digit beat follows once the previous frame has sent its last beat.
// The scan frame sends one beat per cycle while digit is ready, twelve per refresh.
// Synchronous reset empties the pipeline and the frame; no clearing pass.
// A stall on digit holds the frame index and backs up the pipeline stage by stage.

module three_row_decimal_led_scanner_core (
  input  logic                 clk,
  input  logic                 rst,
  trdls_req_if.sink            req,
  trdls_digit_if.source        digit
);

  trdls_pkg::lane_t pipe [trdls_pkg::STAGES][trdls_pkg::ROWS];
  trdls_pkg::lane_t pipe_next [trdls_pkg::STAGES][trdls_pkg::ROWS];
  logic [trdls_pkg::STAGES-1:0] vld;
  logic [trdls_pkg::STAGES:0]   rdy;

  trdls_pkg::byte_t frame_seg [trdls_pkg::DIGITS];
  logic             frame_valid;
  logic [3:0]       scan_idx;
  logic             out_fire;
  logic             load;
  logic [15:0]      in_vals [trdls_pkg::ROWS];

  function automatic logic [6:0] thou_of(input logic [15:0] v);
    logic [32:0] p;
    p = {17'd0, v} * trdls_pkg::THOU_RECIP;
    return p[32:26];
  endfunction

  function automatic logic [9:0] rem_of(input logic [15:0] v, input logic [6:0] q);
    logic [15:0] r;
    r = v - ({9'd0, q} * 16'd1000);
    return r[9:0];
  endfunction

  function automatic logic [3:0] hund_of(input logic [9:0] r);
    logic [15:0] p;
    p = {6'd0, r} * 16'd41;
    return p[15:12];
  endfunction

  function automatic logic [6:0] rem2_of(input logic [9:0] r, input logic [3:0] h);
    logic [9:0] d;
    d = r - ({6'd0, h} * 10'd100);
    return d[6:0];
  endfunction

  function automatic logic [3:0] tens_of(input logic [6:0] r);
    logic [14:0] p;
    p = {8'd0, r} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] r, input logic [3:0] t);
    logic [6:0] d;
    d = r - ({3'd0, t} * 7'd10);
    return d[3:0];
  endfunction

  assign in_vals[0] = req.time_value;
  assign in_vals[1] = req.score_value;
  assign in_vals[2] = req.total_value;

  assign out_fire = digit.valid && digit.ready;
  assign load = rdy[trdls_pkg::STAGES] && vld[trdls_pkg::STAGES-1];

  always_comb begin
    rdy[trdls_pkg::STAGES] = !frame_valid || (out_fire && scan_idx == trdls_pkg::LAST_SCAN);
    for (int s = trdls_pkg::STAGES - 1; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign req.ready = rdy[0];

  always_comb begin
    for (int r = 0; r < trdls_pkg::ROWS; r++) begin
      pipe_next[0][r]     = '0;
      pipe_next[0][r].val = in_vals[r];

      pipe_next[1][r]      = pipe[0][r];
      pipe_next[1][r].thou = thou_of(pipe[0][r].val);

      pipe_next[2][r]     = pipe[1][r];
      pipe_next[2][r].rem = rem_of(pipe[1][r].val, pipe[1][r].thou);

      pipe_next[3][r]      = pipe[2][r];
      pipe_next[3][r].hund = hund_of(pipe[2][r].rem);

      pipe_next[4][r]      = pipe[3][r];
      pipe_next[4][r].rem2 = rem2_of(pipe[3][r].rem, pipe[3][r].hund);

      pipe_next[5][r]      = pipe[4][r];
      pipe_next[5][r].tens = tens_of(pipe[4][r].rem2);

      pipe_next[6][r]      = pipe[5][r];
      pipe_next[6][r].ones = ones_of(pipe[5][r].rem2, pipe[5][r].tens);
    end
  end

  // advance each stage when it is empty or the next one takes its beat
  always_ff @(posedge clk) begin
    for (int s = 0; s < trdls_pkg::STAGES; s++) begin
      if (rdy[s]) begin
        pipe[s] <= pipe_next[s];
      end
    end
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= req.valid;
      end
      for (int s = 1; s < trdls_pkg::STAGES; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // load a finished refresh into the scan frame
  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < trdls_pkg::ROWS; r++) begin
        frame_seg[r*4 + 0] <= trdls_pkg::seg_of({3'd0, pipe[6][r].ones});
        frame_seg[r*4 + 1] <= trdls_pkg::seg_of({3'd0, pipe[6][r].tens});
        if (r == 0) begin
          frame_seg[2] <= trdls_pkg::seg_of({3'd0, pipe[6][0].hund}) & trdls_pkg::DP_MASK;
          frame_seg[3] <= (pipe[6][0].thou == 7'd0) ? trdls_pkg::SEG_BLANK
                                                    : trdls_pkg::seg_of(pipe[6][0].thou);
        end else begin
          frame_seg[r*4 + 2] <= trdls_pkg::seg_of({3'd0, pipe[6][r].hund});
          frame_seg[r*4 + 3] <= trdls_pkg::seg_of(pipe[6][r].thou);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      scan_idx    <= 4'd0;
    end else begin
      if (out_fire) begin
        scan_idx <= (scan_idx == trdls_pkg::LAST_SCAN) ? 4'd0 : scan_idx + 4'd1;
      end
      if (load) begin
        frame_valid <= 1'b1;
      end else if (out_fire && scan_idx == trdls_pkg::LAST_SCAN) begin
        frame_valid <= 1'b0;
      end
    end
  end

  assign digit.valid            = frame_valid;
  assign digit.select_low_byte  = trdls_pkg::SEL_LO[scan_idx];
  assign digit.select_high_byte = trdls_pkg::SEL_HI[scan_idx];
  assign digit.segment_byte     = frame_seg[scan_idx];
  assign digit.last_digit       = (scan_idx == trdls_pkg::LAST_SCAN);

  a_idle_at_zero: assert property (@(posedge clk) disable iff (rst)
    !frame_valid |-> scan_idx == 4'd0)
    else $error("scan index off zero with empty frame");

  a_idx_advance: assert property (@(posedge clk) disable iff (rst)
    out_fire && scan_idx != trdls_pkg::LAST_SCAN |=> scan_idx == $past(scan_idx) + 4'd1)
    else $error("scan index did not advance");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !digit.ready |=> $stable(scan_idx) && frame_valid)
    else $error("scan frame moved under stall");

  a_req_enters: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> vld[0])
    else $error("accepted request missing from first stage");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !frame_valid || (out_fire && digit.last_digit))
    else $error("frame overwritten before last beat");

endmodule
